/* src/cwm_pkg.sv */
`default_nettype none

package cwm_pkg;

    // Sizing
    localparam int PATTERN_MAX    = 48;
    localparam int OFFSET_BITS    = 20;
    localparam int NUM_WORDS      = 6;
    localparam int WORD_BITS      = 64;
    localparam int LENGTH_BITS    = 6;
    localparam int CFG_INDEX_BITS = 3;
    localparam int LEN_BITS       = $clog2(PATTERN_MAX + 2);
    localparam int NUM_CELLS      = PATTERN_MAX + 1;

    // Register map
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MATCH_MODE     = 3'd7;

    // Character codes
    localparam logic [7:0] CHAR_PERIOD   = 8'h2E;
    localparam logic [7:0] CHAR_QUESTION = 8'h3F;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_HYPHEN   = 8'h2D;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // History held by one cell
    typedef struct packed {
        logic [7:0]             ch;
        logic [OFFSET_BITS-1:0] sent;
    } cell_data_t;

    // Per-cell view of the configuration
    typedef struct packed {
        logic [7:0] pat_byte;
        logic       in_use;
        logic       tap_sent;
        logic       tap_prev;
    } cell_ctrl_t;

    // Per-cell contribution to the hit decision
    typedef struct packed {
        logic                   mismatch;
        logic                   sep_hit;
        logic [OFFSET_BITS-1:0] sent_tap;
    } cell_stat_t;

    // Map ASCII upper case onto lower case, leave every other byte alone
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/case_insensitive_word_matcher_core.sv */
`default_nettype none

// Streaming case-insensitive pattern matcher.
//
// Text enters one byte per item on the text channel (text_valid/text_stall);
// first_of_text on a byte starts a new text: offset, history, sentence start
// and hit count restart before that byte. Each hit leaves as one item on the
// match channel (match_valid/match_stall) with its start offset, sentence
// start and running hit number; a byte that ends no hit produces no item.
// The pattern, its length and the mode are written through cfg_valid/
// cfg_ready (always ready); the user must write them only while the
// stream is idle, as the block does not enforce it. The last byte of a
// hit is registered in the evaluation stage, then the hit in the output
// register. Throughput is one byte per cycle unless a new hit waits
// behind a stalled result: the history shifts through a row of 49 cells
// that all compare in the same cycle, feeding a single evaluation stage.
// When the receiver stalls, the pending result holds; text is still taken
// while the evaluation stage can drain, and text_stall rises only when a
// new hit waits behind a stalled result.
// Reset clears the history, counters, flags and config registers (pattern
// length 1, word mode); the stream then counts as a new text at offset 0.
module case_insensitive_word_matcher_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                text_valid,
    output logic                                     text_stall,
    input  wire logic [7:0]                          text_char,
    input  wire logic                                first_of_text,
    output logic                                     match_valid,
    input  wire logic                                match_stall,
    output logic [cwm_pkg::OFFSET_BITS-1:0]          match_position,
    output logic [cwm_pkg::OFFSET_BITS-1:0]          sentence_position,
    output logic [cwm_pkg::OFFSET_BITS-1:0]          match_number,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [cwm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [cwm_pkg::WORD_BITS-1:0]       cfg_data
);

    localparam int OB = cwm_pkg::OFFSET_BITS;
    localparam int LB = cwm_pkg::LEN_BITS;
    localparam int NC = cwm_pkg::NUM_CELLS;

    logic [cwm_pkg::PATTERN_MAX-1:0][7:0] pattern_aligned;
    logic [LB-1:0] len_eff;
    logic          all_mode;

    logic [OB-1:0] offset_reg, offset_next;
    logic [OB-1:0] lss_reg, lss_next;
    logic [OB-1:0] count_reg, count_next;
    logic [LB-1:0] fill_reg, fill_next;
    logic          eval_valid_reg, eval_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic [OB-1:0] pos_reg, pos_next;
    logic [OB-1:0] sent_reg, sent_next;
    logic [OB-1:0] num_reg, num_next;

    logic          accept;
    logic [OB-1:0] t_cur;
    logic [OB-1:0] count_inc;
    logic          hit;
    logic          eval_move;
    logic          mismatch_any;
    logic          sep_any;
    logic [OB-1:0] sent_sel;

    cwm_pkg::cell_data_t head_data;
    cwm_pkg::cell_data_t cell_out  [NC];
    cwm_pkg::cell_ctrl_t cell_ctrl [NC];
    cwm_pkg::cell_stat_t cell_stat [NC];

    assign cfg_ready = 1'b1;

    cwm_config u_config (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (cfg_valid),
        .wr_index        (cfg_index),
        .wr_data         (cfg_data),
        .pattern_aligned (pattern_aligned),
        .len_eff         (len_eff),
        .all_mode        (all_mode)
    );

    assign accept = text_valid && !text_stall;

    // Offset and sentence start for the arriving byte
    always_comb
    begin
        t_cur    = first_of_text ? '0 : offset_reg;
        lss_next = first_of_text ? '0 : lss_reg;
        if (text_char == cwm_pkg::CHAR_PERIOD || text_char == cwm_pkg::CHAR_QUESTION)
        begin
            lss_next = t_cur + OB'(1);
        end
        head_data.ch   = text_char;
        head_data.sent = lss_next;
    end

    // Row of history cells
    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        if (k < cwm_pkg::PATTERN_MAX)
        begin : g_pat
            assign cell_ctrl[k].pat_byte = pattern_aligned[k];
        end
        else
        begin : g_nopat
            assign cell_ctrl[k].pat_byte = 8'h00;
        end
        assign cell_ctrl[k].in_use   = LB'(k) < len_eff;
        assign cell_ctrl[k].tap_sent = LB'(k) == (len_eff - LB'(1));
        assign cell_ctrl[k].tap_prev = LB'(k) == len_eff;

        if (k == 0)
        begin : g_head
            cwm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (accept),
                .clear    (1'b0),
                .data_in  (head_data),
                .ctrl     (cell_ctrl[k]),
                .data_out (cell_out[k]),
                .stat     (cell_stat[k])
            );
        end
        else
        begin : g_body
            cwm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (accept),
                .clear    (first_of_text),
                .data_in  (cell_out[k-1]),
                .ctrl     (cell_ctrl[k]),
                .data_out (cell_out[k]),
                .stat     (cell_stat[k])
            );
        end
    end

    // Gather cell results
    always_comb
    begin
        mismatch_any = 1'b0;
        sep_any      = 1'b0;
        sent_sel     = '0;
        for (int k = 0; k < NC; k++)
        begin
            mismatch_any = mismatch_any | cell_stat[k].mismatch;
            sep_any      = sep_any | cell_stat[k].sep_hit;
            sent_sel     = sent_sel | cell_stat[k].sent_tap;
        end
    end

    // Decide the hit for the byte in the evaluation stage
    always_comb
    begin
        hit = eval_valid_reg && (fill_reg >= len_eff) && !mismatch_any &&
              (all_mode || (fill_reg == len_eff) || sep_any);
        eval_move  = eval_valid_reg && (!hit || !out_valid_reg || !match_stall);
        text_stall = eval_valid_reg && !eval_move;
        count_inc  = (count_reg == {OB{1'b1}}) ? count_reg : count_reg + OB'(1);
    end

    // Next state of counters, stages and output register
    always_comb
    begin
        offset_next     = offset_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        eval_valid_next = eval_valid_reg;
        out_valid_next  = out_valid_reg;
        pos_next        = pos_reg;
        sent_next       = sent_reg;
        num_next        = num_reg;

        // Retire the result being taken
        if (out_valid_reg && !match_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Advance the evaluation stage
        if (eval_move)
        begin
            eval_valid_next = 1'b0;
            if (hit)
            begin
                out_valid_next = 1'b1;
                pos_next       = offset_reg - OB'(len_eff);
                sent_next      = sent_sel;
                num_next       = count_inc;
                count_next     = count_inc;
            end
        end

        // Take a new byte
        if (accept)
        begin
            eval_valid_next = 1'b1;
            offset_next     = t_cur + OB'(1);
            if (first_of_text)
            begin
                fill_next  = LB'(1);
                count_next = '0;
            end
            else if (fill_reg < LB'(NC))
            begin
                fill_next = fill_reg + LB'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            lss_reg        <= '0;
            count_reg      <= '0;
            fill_reg       <= '0;
            eval_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            offset_reg     <= offset_next;
            if (accept)
            begin
                lss_reg <= lss_next;
            end
            count_reg      <= count_next;
            fill_reg       <= fill_next;
            eval_valid_reg <= eval_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        sent_reg <= sent_next;
        num_reg  <= num_next;
    end

    assign match_valid       = out_valid_reg;
    assign match_position    = pos_reg;
    assign sentence_position = sent_reg;
    assign match_number      = num_reg;

    // Input stalls only behind a hit that cannot leave
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> (eval_valid_reg && out_valid_reg && match_stall))
        else $error("text stalled without a blocked result");

    // Fill count stays within the history depth
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LB'(NC))
        else $error("fill count out of range");

    // A reported hit always has a nonzero number
    a_number_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        match_valid |-> (match_number != '0))
        else $error("hit reported with number zero");

    // A new text restarts the offset
    a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && first_of_text) |=> (offset_reg == OB'(1) && fill_reg == LB'(1)))
        else $error("offset not restarted at new text");

    // Every accepted byte reaches the evaluation stage
    a_eval_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> eval_valid_reg)
        else $error("accepted byte not evaluated");

endmodule

`default_nettype wire

/* src/cwm_cell.sv */
`default_nettype none

module cwm_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               shift_en,
    input  wire logic               clear,
    input  wire cwm_pkg::cell_data_t data_in,
    input  wire cwm_pkg::cell_ctrl_t ctrl,
    output cwm_pkg::cell_data_t     data_out,
    output cwm_pkg::cell_stat_t     stat
);

    cwm_pkg::cell_data_t data_reg;
    cwm_pkg::cell_data_t data_next;

    // Take the neighbor's entry on each item, drop history at a new text
    always_comb
    begin
        data_next = data_reg;
        if (shift_en)
        begin
            data_next = clear ? '0 : data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data_out = data_reg;

    // Compare against the aligned pattern byte and offer the tapped values
    always_comb
    begin
        stat.mismatch = ctrl.in_use &&
            (cwm_pkg::fold_case(data_reg.ch) != cwm_pkg::fold_case(ctrl.pat_byte));
        stat.sep_hit  = ctrl.tap_prev &&
            (data_reg.ch == cwm_pkg::CHAR_SPACE || data_reg.ch == cwm_pkg::CHAR_HYPHEN);
        stat.sent_tap = ctrl.tap_sent ? data_reg.sent : '0;
    end

endmodule

`default_nettype wire

/* src/cwm_config.sv */
`default_nettype none

module cwm_config (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  wr_en,
    input  wire logic [cwm_pkg::CFG_INDEX_BITS-1:0]    wr_index,
    input  wire logic [cwm_pkg::WORD_BITS-1:0]         wr_data,
    output logic [cwm_pkg::PATTERN_MAX-1:0][7:0]       pattern_aligned,
    output logic [cwm_pkg::LEN_BITS-1:0]               len_eff,
    output logic                                       all_mode
);

    logic [cwm_pkg::WORD_BITS-1:0]   word_reg [cwm_pkg::NUM_WORDS];
    logic [cwm_pkg::LENGTH_BITS-1:0] length_reg;
    logic                            mode_reg;

    logic [cwm_pkg::PATTERN_MAX-1:0][7:0] pat_bytes;
    logic [cwm_pkg::PATTERN_MAX*8-1:0]    rev_vec;
    logic [cwm_pkg::LEN_BITS-1:0]         shift_bytes;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < cwm_pkg::NUM_WORDS; w++)
            begin
                word_reg[w] <= '0;
            end
            length_reg <= cwm_pkg::LENGTH_BITS'(1);
            mode_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                cwm_pkg::REG_PATTERN_LENGTH: length_reg <= wr_data[cwm_pkg::LENGTH_BITS-1:0];
                cwm_pkg::REG_MATCH_MODE:     mode_reg   <= wr_data[0];
                default:                     word_reg[wr_index] <= wr_data;
            endcase
        end
    end

    // Unpack pattern bytes; bytes beyond the words read as zero
    for (genvar j = 0; j < cwm_pkg::PATTERN_MAX; j++)
    begin : g_byte
        if (j < cwm_pkg::NUM_WORDS * 8)
        begin : g_held
            assign pat_bytes[j] = word_reg[j / 8][8 * (j % 8) +: 8];
        end
        else
        begin : g_pad
            assign pat_bytes[j] = 8'h00;
        end
        assign rev_vec[8 * j +: 8] = pat_bytes[cwm_pkg::PATTERN_MAX - 1 - j];
    end

    // Clamp the length into 1..PATTERN_MAX
    always_comb
    begin
        if (length_reg == '0)
        begin
            len_eff = cwm_pkg::LEN_BITS'(1);
        end
        else if ({1'b0, length_reg} > (cwm_pkg::LENGTH_BITS + 1)'(cwm_pkg::PATTERN_MAX))
        begin
            len_eff = cwm_pkg::LEN_BITS'(cwm_pkg::PATTERN_MAX);
        end
        else
        begin
            len_eff = cwm_pkg::LEN_BITS'(length_reg);
        end
    end

    // Align so that cell k sees pattern byte len-1-k
    assign shift_bytes     = cwm_pkg::LEN_BITS'(cwm_pkg::PATTERN_MAX) - len_eff;
    assign pattern_aligned = rev_vec >> {shift_bytes, 3'b000};
    assign all_mode        = mode_reg;

endmodule

`default_nettype wire
